FILE: hw/rtl/hcf_pkg.sv
// Shared types, constants and helpers for the hex length chunk framer.
// No dependencies; imported by every module of the block except hcf_ram.
package hcf_pkg;

  typedef enum logic [1:0] {
    ACT_BYTE   = 2'd0,
    ACT_FLUSH  = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    SEL_HDR  = 2'd0,
    SEL_DATA = 2'd1,
    SEL_MARK = 2'd2
  } out_sel_t;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_D    = 8'h64;
  localparam int         HDR_LEN   = 8;
  localparam int         HEX_DIGITS = 7;

  localparam logic       REG_CHUNK_SIZE  = 1'b0;
  localparam logic [5:0] CHUNK_SIZE_RST  = 6'd32;

  typedef struct packed {
    logic     accept;
    logic     store_in;
    logic     store_item;
    logic     clr_cnt;
    logic     inc_cnt;
    logic     rd_en;
    logic     rd_first;
    logic     fill_clr;
    logic     load_out;
    out_sel_t sel;
    logic     out_last;
  } hcf_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic fill_ge_cap;
    logic cnt_is7;
    logic data_last;
    logic slot_free;
  } hcf_sts_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] v;
    v = {4'h0, n};
    if (n < 4'd10) begin
      return CHAR_ZERO + v;
    end else begin
      return 8'h57 + v;
    end
  endfunction

endpackage

FILE: hw/rtl/hcf_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module hcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/hcf_ctrl.sv
// Sequencer for the chunk framer: accepts items and steps through header,
// payload and end marker. Depends on hcf_pkg.
module hcf_ctrl import hcf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [1:0] action,
  input  hcf_sts_t  sts,
  output hcf_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_HDR     = 6'b000010,
    S_DATA_RD = 6'b000100,
    S_DATA_WR = 6'b001000,
    S_MARK    = 6'b010000,
    S_STORE   = 6'b100000
  } state_t;

  state_t  state, state_next;
  action_t act, act_next;
  logic    accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      act   <= ACT_NONE;
    end else begin
      state <= state_next;
      act   <= act_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    act_next   = act;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          act_next   = action_t'(action);
          case (action_t'(action))
            ACT_BYTE: begin
              if (sts.fill_ge_cap) begin
                cmd.clr_cnt = 1'b1;
                state_next  = S_HDR;
              end else begin
                cmd.store_in = 1'b1;
              end
            end
            ACT_FLUSH: begin
              if (!sts.fill_zero) begin
                cmd.clr_cnt = 1'b1;
                state_next  = S_HDR;
              end
            end
            ACT_FINISH: begin
              cmd.clr_cnt = 1'b1;
              state_next  = sts.fill_zero ? S_MARK : S_HDR;
            end
            default: ;
          endcase
        end
      end
      S_HDR: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.sel      = SEL_HDR;
          if (sts.cnt_is7) begin
            cmd.clr_cnt = 1'b1;
            state_next  = S_DATA_RD;
          end else begin
            cmd.inc_cnt = 1'b1;
          end
        end
      end
      S_DATA_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_first = 1'b1;
        state_next   = S_DATA_WR;
      end
      S_DATA_WR: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.sel      = SEL_DATA;
          if (sts.data_last) begin
            cmd.out_last = (act != ACT_FINISH);
            cmd.fill_clr = 1'b1;
            cmd.clr_cnt  = 1'b1;
            if (act == ACT_BYTE) begin
              state_next = S_STORE;
            end else if (act == ACT_FINISH) begin
              state_next = S_MARK;
            end else begin
              state_next = S_IDLE;
            end
          end else begin
            cmd.inc_cnt = 1'b1;
            cmd.rd_en   = 1'b1;
          end
        end
      end
      S_MARK: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.sel      = SEL_MARK;
          cmd.out_last = sts.cnt_is7;
          if (sts.cnt_is7) begin
            state_next = S_IDLE;
          end else begin
            cmd.inc_cnt = 1'b1;
          end
        end
      end
      S_STORE: begin
        cmd.store_item = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/hcf_dpath.sv
// Datapath of the chunk framer: chunk buffer, fill level, byte counter,
// header digit generation and output register. Depends on hcf_pkg, hcf_ram.
module hcf_dpath import hcf_pkg::*; #(
  parameter int BUF_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  hcf_cmd_t   cmd,
  output hcf_sts_t   sts,
  input  logic [7:0] data_byte,
  input  logic [5:0] chunk_size,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  localparam int FW = $clog2(BUF_DEPTH + 1);
  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CW = (FW > 3) ? FW : 3;

  logic [FW-1:0] fill;
  logic [CW-1:0] cnt;
  logic [CW:0]   cnt_inc;
  logic [CW:0]   fill_ext;
  logic [7:0]    item_byte;
  logic [6:0]    cap;
  logic [27:0]   hdr_val;
  logic [4:0]    shamt;
  logic [3:0]    nibble;
  logic [7:0]    hdr_byte;
  logic [7:0]    byte_next;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata;

  assign cnt_inc  = (CW+1)'(cnt) + (CW+1)'(1);
  assign fill_ext = (CW+1)'(fill);

  always_comb begin
    if (chunk_size == 6'd0) begin
      cap = 7'd1;
    end else if (7'(chunk_size) > 7'(BUF_DEPTH)) begin
      cap = 7'(BUF_DEPTH);
    end else begin
      cap = 7'(chunk_size);
    end
  end

  assign sts.fill_zero   = (fill == '0);
  assign sts.fill_ge_cap = (7'(fill) >= cap);
  assign sts.cnt_is7     = (cnt == CW'(HDR_LEN - 1));
  assign sts.data_last   = (cnt_inc == fill_ext);
  assign sts.slot_free   = ~out_valid | out_ready;

  assign we    = cmd.store_in | cmd.store_item;
  assign waddr = cmd.store_in ? AW'(fill) : '0;
  assign wdata = cmd.store_in ? data_byte : item_byte;
  assign raddr = cmd.rd_first ? '0 : AW'(cnt_inc);

  hcf_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // digit i of the header is bits 4*(6-i) up of the fill level
  assign hdr_val  = 28'(fill);
  assign shamt    = {3'(HEX_DIGITS - 1) - cnt[2:0], 2'b00};
  assign nibble   = 4'(hdr_val >> shamt);
  assign hdr_byte = sts.cnt_is7 ? CHAR_D : hex_char(nibble);

  always_comb begin
    case (cmd.sel)
      SEL_HDR:  byte_next = hdr_byte;
      SEL_DATA: byte_next = rdata;
      SEL_MARK: byte_next = sts.cnt_is7 ? CHAR_D : CHAR_ZERO;
      default:  byte_next = CHAR_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.store_in) begin
        fill <= fill + FW'(1);
      end else if (cmd.store_item) begin
        fill <= FW'(1);
      end else if (cmd.fill_clr) begin
        fill <= '0;
      end
      if (cmd.clr_cnt) begin
        cnt <= '0;
      end else if (cmd.inc_cnt) begin
        cnt <= cnt + CW'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_byte <= data_byte;
    end
    if (cmd.load_out) begin
      out_byte    <= byte_next;
      last_of_run <= cmd.out_last;
    end
  end

endmodule

FILE: hw/rtl/hex_length_chunk_framer_core.sv
// Hex length chunk framer top level: APB register, sequencer and datapath.
// Depends on hcf_pkg, hcf_ctrl, hcf_dpath.
//
// Input channel (in_valid/in_ready, action, data_byte) takes one item per
// transfer. A payload byte with room in the buffer is stored as it is
// taken, so such bytes go in back to back. A byte into a full buffer, a
// flush of a non-empty buffer or a finish starts a run on the output channel
// (out_valid/out_ready, out_byte, last_of_run): an 8-byte hex length header,
// a read of the first buffered byte, then one payload byte per cycle from the
// chunk buffer RAM while the receiver is ready; a finish then adds the 8-byte
// end marker, and a byte that found the buffer full is then stored as the
// first byte of the next chunk. A finish on an empty buffer gives only the
// end marker. The first output byte is registered from S_HDR or S_MARK,
// entered after the item is taken. in_ready is low while a run is being
// produced. A stalled receiver holds the output register and the sequencer
// waits; nothing is lost. Reset empties the buffer and sets chunk_size
// to 32. chunk_size (address 0) is to be written by the user only while
// the block is idle; the block itself does not enforce this.
module hex_length_chunk_framer_core import hcf_pkg::*; #(
  parameter int BUF_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_run
);

  logic [5:0] chunk_size;
  hcf_cmd_t   cmd;
  hcf_sts_t   sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHUNK_SIZE) ? {26'd0, chunk_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size <= CHUNK_SIZE_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CHUNK_SIZE)) begin
      chunk_size <= pwdata[5:0];
    end
  end

  hcf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .sts      (sts),
    .cmd      (cmd)
  );

  hcf_dpath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .data_byte   (data_byte),
    .chunk_size  (chunk_size),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

FILE: hw/rtl/hcf_checker.sv
// Port-level checks for the chunk framer, bound to the top level.
// Depends on hcf_pkg and hex_length_chunk_framer_core.
module hcf_checker import hcf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("output transfer changed while stalled");

  a_run_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> !in_ready)
    else $error("input taken in the middle of a run");

  a_finish_runs: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (action == ACT_FINISH) |=> !in_ready)
    else $error("finish produced no run");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind hex_length_chunk_framer_core hcf_checker u_hcf_checker (.*);
